@@ hdl/sobb_pkg.sv @@
// sobb_pkg: shared constants and types for the segment versus oriented box test
// depends on nothing; imported by sobb_wmul and segment_obb_slab_test
package sobb_pkg;

    localparam int CoordW  = 32;            // Q16.16 coordinates
    localparam int RowW    = 48;            // three packed Q2.14 entries
    localparam int ElemW   = 16;            // one packed entry
    localparam int DiffW   = CoordW + 1;    // exact coordinate difference
    localparam int ProdW   = DiffW + ElemW; // entry times difference
    localparam int SumW    = ProdW + 2;     // sum of three products
    localparam int HeW     = 40;            // widened half extent, signed
    localparam int FracW   = SumW + 1;      // enter/leave numerators and denominators
    localparam int WideW   = 2 * FracW;     // cross products
    localparam int HalfW   = FracW / 2;     // split point of the wide multiplier
    localparam int PartW   = 2 * (HalfW + 1);
    localparam int CfgIdxW = 3;
    localparam int HeShift = 22;            // Q8.8 to units of 2^-30

    localparam logic [HeW-1:0] MarginUnits = HeW'(53687091);

    localparam logic [RowW-1:0] RotRow0Rst = RowW'(64'h0000_0000_4000);
    localparam logic [RowW-1:0] RotRow1Rst = RowW'(64'h0000_4000_0000);
    localparam logic [RowW-1:0] RotRow2Rst = RowW'(64'h4000_0000_0000);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_ROT_ROW0 = 3'd3,
        CFG_ROT_ROW1 = 3'd4,
        CFG_ROT_ROW2 = 3'd5,
        CFG_HALF_EXT = 3'd6
    } t_cfg_idx;

endpackage

@@ hdl/sobb_wmul.sv @@
// sobb_wmul: two-stage signed multiplier for the fraction cross products
// splits each operand in halves; depends on sobb_pkg
module sobb_wmul (
    input  logic                                 i_clk,
    input  logic signed [sobb_pkg::FracW-1:0]    i_a,
    input  logic signed [sobb_pkg::FracW-1:0]    i_b,
    output logic signed [sobb_pkg::WideW-1:0]    o_p
);
    import sobb_pkg::*;

    logic signed [HalfW:0]   w_ah, w_al, w_bh, w_bl;
    logic signed [PartW-1:0] r_hh, r_hl, r_lh, r_ll;
    logic signed [WideW-1:0] r_p;

    // high halves signed, low halves zero extended
    assign w_ah = (HalfW+1)'($signed(i_a[FracW-1:HalfW]));
    assign w_bh = (HalfW+1)'($signed(i_b[FracW-1:HalfW]));
    assign w_al = $signed({1'b0, i_a[HalfW-1:0]});
    assign w_bl = $signed({1'b0, i_b[HalfW-1:0]});

    always_ff @(posedge i_clk) begin
        r_hh <= PartW'(w_ah) * PartW'(w_bh);
        r_hl <= PartW'(w_ah) * PartW'(w_bl);
        r_lh <= PartW'(w_al) * PartW'(w_bh);
        r_ll <= PartW'(w_al) * PartW'(w_bl);
        r_p  <= (WideW'(r_hh) <<< (2 * HalfW))
              + ((WideW'(r_hl) + WideW'(r_lh)) <<< HalfW)
              + WideW'(r_ll);
    end

    assign o_p = r_p;

endmodule

@@ hdl/segment_obb_slab_test.sv @@
// segment_obb_slab_test: segment against one oriented box, one query per cycle
// depends on sobb_pkg and sobb_wmul
//
// usage: the box (center, three rotation rows, half extents) is loaded over the
// configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data);
// ready is always high and an index past the last register is ignored.
// a query transaction is taken on any cycle with i_start high and o_busy low;
// o_busy stays low, so a new segment can enter on every clock.
// each query gives one result: o_valid pulses for one cycle with o_hit, in
// query order. throughput is one query per cycle; the result passes through
// the pipeline of difference, rotate, sum, slab setup, two cross-product
// multiplier stages and the final interval compare.
// the receiver has no way to stall, so nothing is held back at the output.
// synchronous reset (i_rst_n low) empties the pipeline and loads the
// identity rotation, zero center and zero half extents.
// registers should only be rewritten when no query is in flight.
module segment_obb_slab_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_start_x,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_start_y,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_start_z,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_end_x,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_end_y,
    input  logic signed [sobb_pkg::CoordW-1:0]  i_end_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sobb_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [sobb_pkg::RowW-1:0]           i_cfg_data,
    output logic                                o_valid,
    output logic                                o_hit
);
    import sobb_pkg::*;

    // configuration
    logic signed [CoordW-1:0] r_ctr [3];
    logic [RowW-1:0]          r_rot [3];
    logic [RowW-1:0]          r_he;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0] <= '0;
            r_ctr[1] <= '0;
            r_ctr[2] <= '0;
            r_rot[0] <= RotRow0Rst;
            r_rot[1] <= RotRow1Rst;
            r_rot[2] <= RotRow2Rst;
            r_he     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X: r_ctr[0] <= i_cfg_data[CoordW-1:0];
                CFG_CENTER_Y: r_ctr[1] <= i_cfg_data[CoordW-1:0];
                CFG_CENTER_Z: r_ctr[2] <= i_cfg_data[CoordW-1:0];
                CFG_ROT_ROW0: r_rot[0] <= i_cfg_data;
                CFG_ROT_ROW1: r_rot[1] <= i_cfg_data;
                CFG_ROT_ROW2: r_rot[2] <= i_cfg_data;
                CFG_HALF_EXT: r_he     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // valid bits
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= i_start;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            o_valid <= r_v5;
        end
    end

    // stage 0: direction and offset
    logic signed [CoordW-1:0] w_s [3];
    logic signed [CoordW-1:0] w_e [3];
    logic signed [DiffW-1:0]  r_dir [3];
    logic signed [DiffW-1:0]  r_off [3];

    assign w_s[0] = i_start_x;
    assign w_s[1] = i_start_y;
    assign w_s[2] = i_start_z;
    assign w_e[0] = i_end_x;
    assign w_e[1] = i_end_y;
    assign w_e[2] = i_end_z;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dir[k] <= DiffW'(w_e[k]) - DiffW'(w_s[k]);
            r_off[k] <= DiffW'(w_s[k]) - DiffW'(r_ctr[k]);
        end
    end

    // stage 1: products with the transposed rotation
    logic signed [ProdW-1:0] r_pd [3][3];
    logic signed [ProdW-1:0] r_pm [3][3];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            for (int r = 0; r < 3; r++) begin
                r_pd[a][r] <= ProdW'($signed(r_rot[r][ElemW*a +: ElemW])) * ProdW'(r_dir[r]);
                r_pm[a][r] <= ProdW'($signed(r_rot[r][ElemW*a +: ElemW])) * ProdW'(r_off[r]);
            end
        end
    end

    // stage 2: box-space direction and offset
    logic signed [SumW-1:0] r_d [3];
    logic signed [SumW-1:0] r_m [3];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_d[a] <= SumW'(r_pd[a][0]) + SumW'(r_pd[a][1]) + SumW'(r_pd[a][2]);
            r_m[a] <= SumW'(r_pm[a][0]) + SumW'(r_pm[a][1]) + SumW'(r_pm[a][2]);
        end
    end

    // stage 3: slab bounds as fractions over a positive denominator
    logic signed [HeW-1:0]   w_hw [3];
    logic signed [FracW-1:0] w_mp [3];
    logic                    w_par [3];
    logic                    r_par3 [3];
    logic                    r_pok3 [3];
    logic signed [FracW-1:0] r_en [3];
    logic signed [FracW-1:0] r_lv [3];
    logic signed [FracW-1:0] r_den [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_hw[a]  = $signed({2'b00, r_he[ElemW*a +: ElemW], HeShift'(0)}) + $signed(MarginUnits);
            w_par[a] = (r_d[a] >= -SumW'(1)) && (r_d[a] <= SumW'(1));
            w_mp[a]  = r_d[a][SumW-1] ? -FracW'(r_m[a]) : FracW'(r_m[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_par3[a] <= w_par[a];
            r_pok3[a] <= (r_m[a] >= -SumW'(w_hw[a])) && (r_m[a] <= SumW'(w_hw[a]));
            r_den[a]  <= r_d[a][SumW-1] ? -FracW'(r_d[a]) : FracW'(r_d[a]);
            r_en[a]   <= -FracW'(w_hw[a]) - w_mp[a];
            r_lv[a]   <= FracW'(w_hw[a]) - w_mp[a];
        end
    end

    // stages 4 and 5: per-axis checks ride along the cross-product multipliers
    logic r_par4 [3], r_par5 [3];
    logic r_ok4 [3],  r_ok5 [3];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_par4[a] <= r_par3[a];
            r_par5[a] <= r_par4[a];
            // parallel axis: start inside; otherwise entry <= 1 and exit >= 0
            r_ok4[a]  <= r_par3[a] ? r_pok3[a] : ((r_en[a] <= r_den[a]) && !r_lv[a][FracW-1]);
            r_ok5[a]  <= r_ok4[a];
        end
    end

    // entry of axis i against exit of axis j: en_i * den_j <= lv_j * den_i
    logic signed [WideW-1:0] w_pl [3][3];
    logic signed [WideW-1:0] w_pr [3][3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            if (gi != gj) begin : g_pair
                sobb_wmul u_left (
                    .i_clk (i_clk),
                    .i_a   (r_en[gi]),
                    .i_b   (r_den[gj]),
                    .o_p   (w_pl[gi][gj])
                );
                sobb_wmul u_right (
                    .i_clk (i_clk),
                    .i_a   (r_lv[gj]),
                    .i_b   (r_den[gi]),
                    .o_p   (w_pr[gi][gj])
                );
            end else begin : g_diag
                assign w_pl[gi][gj] = '0;
                assign w_pr[gi][gj] = '0;
            end
        end
    end

    // stage 6: interval compare
    logic w_hit;

    always_comb begin
        w_hit = r_ok5[0] && r_ok5[1] && r_ok5[2];
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if (a != b && !r_par5[a] && !r_par5[b] && (w_pl[a][b] > w_pr[a][b])) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= w_hit;
    end

endmodule
